// ----- src/assert_macros.svh -----
// Assertion macros shared by the background subtractor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(name, clk, rstn, trig, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error("assertion failed: expected follow-up missing");

`endif

// ----- src/ravbs_pkg.sv -----
// Types and constants shared by the background subtractor modules.
`default_nettype none

package ravbs_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_RATE      = 3'd1;
    localparam logic [2:0] REG_X_LOW     = 3'd2;
    localparam logic [2:0] REG_X_HIGH    = 3'd3;
    localparam logic [2:0] REG_Y_LOW     = 3'd4;
    localparam logic [2:0] REG_Y_HIGH    = 3'd5;

    // Reset values of the configuration registers.
    localparam logic signed [7:0] THRESHOLD_RESET = -8'sd10;
    localparam logic [15:0]       RATE_RESET      = 16'd2185;
    localparam logic [8:0]        COORD_LOW_RESET = 9'd0;
    localparam logic [8:0]        COORD_HIGH_RESET = 9'd511;

    // Luma weights in Q0.16, summing to one.
    localparam logic signed [17:0] WEIGHT_RED   = 18'sd19595;
    localparam logic signed [17:0] WEIGHT_GREEN = 18'sd38470;
    localparam logic signed [17:0] WEIGHT_BLUE  = 18'sd7471;

    // One in Q0.16, for the complementary blend weight.
    localparam logic [16:0] RATE_ONE = 17'h10000;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // What the back end must do with a pixel.
    typedef enum logic [1:0] {
        CMD_PASS   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_UPDATE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cmd_t;

    // Settings the back end needs.
    typedef struct packed {
        logic signed [7:0] threshold;
        logic [15:0]       rate;
    } cfg_t;

endpackage

`default_nettype wire

// ----- src/ravbs_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ravbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, and a read port that returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/ravbs_front.sv -----
// Front end: configuration registers, pixel classification and address forming.
`default_nettype none

module ravbs_front
    import ravbs_pkg::*;
#(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512,
    parameter int ADDR_W       = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_addr,
    input  wire logic [15:0]       cfg_wr_data,
    input  wire logic [8:0]        pixel_x,
    input  wire logic [8:0]        pixel_y,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    input  wire logic              load_background,
    output cmd_t                   cmd,
    output logic      [ADDR_W-1:0] cmd_addr,
    output cfg_t                   cfg
);

    localparam logic [12:0] FW = 13'(FRAME_WIDTH);
    localparam logic [12:0] FH = 13'(FRAME_HEIGHT);

    logic signed [7:0] threshold_reg;
    logic [15:0]       rate_reg;
    logic [8:0]        x_low_reg;
    logic [8:0]        x_high_reg;
    logic [8:0]        y_low_reg;
    logic [8:0]        y_high_reg;

    logic       in_frame;
    logic [8:0] x_min, x_max, y_min, y_max;
    logic       x_inside, y_inside;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            rate_reg      <= RATE_RESET;
            x_low_reg     <= COORD_LOW_RESET;
            x_high_reg    <= COORD_HIGH_RESET;
            y_low_reg     <= COORD_LOW_RESET;
            y_high_reg    <= COORD_HIGH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_THRESHOLD: threshold_reg <= $signed(cfg_wr_data[7:0]);
                REG_RATE:      rate_reg      <= cfg_wr_data;
                REG_X_LOW:     x_low_reg     <= cfg_wr_data[8:0];
                REG_X_HIGH:    x_high_reg    <= cfg_wr_data[8:0];
                REG_Y_LOW:     y_low_reg     <= cfg_wr_data[8:0];
                REG_Y_HIGH:    y_high_reg    <= cfg_wr_data[8:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.rate      = rate_reg;

    // The corners may be given in either order.
    assign x_min = (x_low_reg < x_high_reg) ? x_low_reg : x_high_reg;
    assign x_max = (x_low_reg < x_high_reg) ? x_high_reg : x_low_reg;
    assign y_min = (y_low_reg < y_high_reg) ? y_low_reg : y_high_reg;
    assign y_max = (y_low_reg < y_high_reg) ? y_high_reg : y_low_reg;

    // Strictly inside, leaving out the line next to the larger corner too.
    assign x_inside = (pixel_x > x_min) && ({1'b0, pixel_x} + 10'd1 < {1'b0, x_max});
    assign y_inside = (pixel_y > y_min) && ({1'b0, pixel_y} + 10'd1 < {1'b0, y_max});

    assign in_frame = ({4'd0, pixel_x} < FW) && ({4'd0, pixel_y} < FH);

    // Classify the pixel.
    always_comb begin
        cmd.red   = red;
        cmd.green = green;
        cmd.blue  = blue;
        if (!in_frame) begin
            cmd.kind = CMD_PASS;
        end else if (load_background) begin
            cmd.kind = CMD_LOAD;
        end else if (x_inside && y_inside) begin
            cmd.kind = CMD_UPDATE;
        end else begin
            cmd.kind = CMD_PASS;
        end
    end

    // Row-major store address; only meaningful for pixels inside the frame.
    assign cmd_addr = ADDR_W'(pixel_y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(pixel_x);

endmodule

`default_nettype wire

// ----- src/ravbs_queue.sv -----
// Short command queue that decouples the front end from the back end.
`default_nettype none
`include "assert_macros.svh"

module ravbs_queue
    import ravbs_pkg::*;
#(
    parameter int ADDR_W = 18
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire cmd_t              push_cmd,
    input  wire logic [ADDR_W-1:0] push_addr,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output cmd_t                   head_cmd,
    output logic      [ADDR_W-1:0] head_addr
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] DEPTH_COUNT = (PTR_W + 1)'(QUEUE_DEPTH);

    cmd_t              cmd_reg  [QUEUE_DEPTH];
    logic [ADDR_W-1:0] addr_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;

    assign full       = (count_reg == DEPTH_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = cmd_reg[rd_ptr_reg];
    assign head_addr  = addr_reg[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_reg[wr_ptr_reg]  <= push_cmd;
            addr_reg[wr_ptr_reg] <= push_addr;
        end
    end

    `ASSERT_NEVER(a_pop_when_empty, aclk, aresetn, pop && !head_valid)
    `ASSERT_NEVER(a_count_overflow, aclk, aresetn, count_reg > DEPTH_COUNT)

endmodule

`default_nettype wire

// ----- src/ravbs_back.sv -----
// Back end: background read, difference and blend pipeline, write-back and result register.
`default_nettype none
`include "assert_macros.svh"

module ravbs_back
    import ravbs_pkg::*;
#(
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              head_valid,
    input  wire cmd_t              head_cmd,
    input  wire logic [ADDR_W-1:0] head_addr,
    output logic                   pop,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic                   res_changed,
    output logic      [7:0]        res_diff
);

    // Stage 1: background word arrives from the store.
    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [23:0]       bg;

    // Stage 2: registered products.
    logic              s2_valid_reg;
    cmd_t              s2_cmd_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic signed [26:0] s2_pr_reg, s2_pg_reg, s2_pb_reg;
    logic [23:0]       s2_br_reg, s2_bg_reg, s2_bb_reg;
    logic [24:0]       s2_cr_reg, s2_cg_reg, s2_cb_reg;

    // Result register.
    logic       out_valid_reg;
    logic       out_changed_reg;
    logic [7:0] out_diff_reg;

    logic advance, hazard, issue;
    logic s1_writes, s2_writes;

    logic signed [8:0]  d_r, d_g, d_b;
    logic [16:0]        inv_rate;
    logic signed [27:0] dsum;
    logic               round_up;
    logic [7:0]         diff;
    logic               below;
    logic [24:0]        sum_r, sum_g, sum_b;
    logic [23:0]        blended;
    logic               ram_we;
    logic [23:0]        ram_wdata;
    logic               s2_changed;
    logic [7:0]         s2_diff;

    // The whole pipeline moves when the result register can take a new value.
    assign advance = !out_valid_reg || res_ready;

    // An update must not read a location that an item still in flight may write.
    assign s1_writes = s1_valid_reg && (s1_cmd_reg.kind != CMD_PASS);
    assign s2_writes = s2_valid_reg && (s2_cmd_reg.kind != CMD_PASS);
    assign hazard = (head_cmd.kind == CMD_UPDATE)
                 && ((s1_writes && (s1_addr_reg == head_addr))
                  || (s2_writes && (s2_addr_reg == head_addr)));
    assign issue = head_valid && !hazard && advance;
    assign pop   = issue;

    ravbs_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s2_addr_reg),
        .wr_data (ram_wdata),
        .rd_en   (issue && (head_cmd.kind == CMD_UPDATE)),
        .rd_addr (head_addr),
        .rd_data (bg)
    );

    // Stage 1 differences and blend weights.
    assign d_r = $signed({1'b0, s1_cmd_reg.red})   - $signed({1'b0, bg[23:16]});
    assign d_g = $signed({1'b0, s1_cmd_reg.green}) - $signed({1'b0, bg[15:8]});
    assign d_b = $signed({1'b0, s1_cmd_reg.blue})  - $signed({1'b0, bg[7:0]});
    assign inv_rate = RATE_ONE - {1'b0, cfg.rate};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload moves with the pipeline.
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_cmd_reg  <= head_cmd;
            s1_addr_reg <= head_addr;
            s2_cmd_reg  <= s1_cmd_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_pr_reg   <= d_r * WEIGHT_RED;
            s2_pg_reg   <= d_g * WEIGHT_GREEN;
            s2_pb_reg   <= d_b * WEIGHT_BLUE;
            s2_br_reg   <= cfg.rate * s1_cmd_reg.red;
            s2_bg_reg   <= cfg.rate * s1_cmd_reg.green;
            s2_bb_reg   <= cfg.rate * s1_cmd_reg.blue;
            s2_cr_reg   <= inv_rate * bg[23:16];
            s2_cg_reg   <= inv_rate * bg[15:8];
            s2_cb_reg   <= inv_rate * bg[7:0];
            out_changed_reg <= s2_changed;
            out_diff_reg    <= s2_diff;
        end
    end

    // Stage 2: weighted sum, divided by 65536 with truncation toward zero.
    assign dsum = {s2_pr_reg[26], s2_pr_reg} + {s2_pg_reg[26], s2_pg_reg}
                + {s2_pb_reg[26], s2_pb_reg};
    assign round_up = dsum[27] && (dsum[15:0] != 16'd0);
    assign diff     = dsum[23:16] + {7'd0, round_up};
    assign below    = $signed(diff) < cfg.threshold;

    // Blend each channel toward the pixel; the sum never exceeds 24 bits.
    assign sum_r = {1'b0, s2_br_reg} + s2_cr_reg;
    assign sum_g = {1'b0, s2_bg_reg} + s2_cg_reg;
    assign sum_b = {1'b0, s2_bb_reg} + s2_cb_reg;
    assign blended = {sum_r[23:16], sum_g[23:16], sum_b[23:16]};

    // Write-back and result for the item leaving stage 2.
    always_comb begin
        ram_we     = 1'b0;
        ram_wdata  = blended;
        s2_changed = 1'b0;
        s2_diff    = 8'd0;
        if (s2_cmd_reg.kind == CMD_LOAD) begin
            ram_we    = s2_valid_reg && advance;
            ram_wdata = {s2_cmd_reg.red, s2_cmd_reg.green, s2_cmd_reg.blue};
        end else if (s2_cmd_reg.kind == CMD_UPDATE) begin
            ram_we     = s2_valid_reg && advance && below;
            s2_changed = !below;
            s2_diff    = diff;
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_changed = out_changed_reg;
    assign res_diff    = out_diff_reg;

    `ASSERT_NEXT(a_write_gives_unchanged, aclk, aresetn, ram_we,
                 out_valid_reg && !out_changed_reg)
    `ASSERT_NEVER(a_read_after_pending_write, aclk, aresetn,
                  issue && (head_cmd.kind == CMD_UPDATE) && s2_writes
                  && (s2_addr_reg == head_addr))

endmodule

`default_nettype wire

// ----- src/running_average_background_subtractor.sv -----
// Running-average background subtractor: one RGB pixel in, one change result out.
// Throughput: one pixel per cycle while the output is not stalled; an update to a
// location that one of the two items ahead of it in the pipeline may still write waits.
// Path from input transaction to result: queue, store read, products, result register.
// A four-entry command queue takes input while the result register is stalled.
// Reset (aresetn, synchronous, active low) restores the registers and empties the
// pipeline; the background store is not cleared and must be loaded before use.
`default_nettype none

module running_average_background_subtractor
    import ravbs_pkg::*;
#(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wr_data,
    // Pixel input.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pixel_x[8:0], pixel_y[17:9], red[25:18], green[33:26], blue[41:34], zero[47:42]
    input  wire logic [47:0] s_tdata,
    // load_background[0]
    input  wire logic        s_tuser,
    // Result output.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // changed[0], luma_difference[8:1], zero[15:9]
    output logic      [15:0] m_tdata
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    cmd_t              front_cmd;
    logic [ADDR_W-1:0] front_addr;
    cfg_t              cfg;
    logic              q_full;
    logic              q_valid;
    cmd_t              q_cmd;
    logic [ADDR_W-1:0] q_addr;
    logic              q_pop;
    logic              res_changed;
    logic [7:0]        res_diff;

    assign s_tready = !q_full;

    ravbs_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .pixel_x         (s_tdata[8:0]),
        .pixel_y         (s_tdata[17:9]),
        .red             (s_tdata[25:18]),
        .green           (s_tdata[33:26]),
        .blue            (s_tdata[41:34]),
        .load_background (s_tuser),
        .cmd             (front_cmd),
        .cmd_addr        (front_addr),
        .cfg             (cfg)
    );

    ravbs_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid && s_tready),
        .push_cmd   (front_cmd),
        .push_addr  (front_addr),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd),
        .head_addr  (q_addr)
    );

    ravbs_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .head_valid  (q_valid),
        .head_cmd    (q_cmd),
        .head_addr   (q_addr),
        .pop         (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_changed (res_changed),
        .res_diff    (res_diff)
    );

    assign m_tdata = {7'd0, res_diff, res_changed};

endmodule

`default_nettype wire

// ----- test/running_average_background_subtractor_tb.sv -----
// Self-checking testbench for the running-average background subtractor.
`timescale 1ns / 1ps

module running_average_background_subtractor_tb;
    import ravbs_pkg::*;

    localparam int FRAME_W       = 512;
    localparam int SITE_COUNT    = 512 * 512;
    localparam int PROBE_COUNT   = 25;
    localparam int PHASE_COUNT   = 7;
    localparam int PHASE_ITEMS   = 185;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RECENT_LIMIT  = 48;

    // One pixel as it enters the block.
    typedef struct packed {
        logic [8:0] pixel_x;
        logic [8:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       load_background;
    } pixel_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic              changed;
        logic signed [7:0] luma_difference;
    } outcome_t;

    // A directed pixel, with its result typed in where typed is set.
    typedef struct packed {
        logic [8:0]        pixel_x;
        logic [8:0]        pixel_y;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic              load_background;
        logic              typed;
        logic              changed;
        logic signed [7:0] luma_difference;
    } probe_row_t;

    // Directed pixels under the reset settings (region interior is 1 to 509 on both axes).
    localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
        // Loads at both frame corners, then plain pixels there: corner lines are outside.
        '{9'd0,   9'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd511, 9'd511, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd0,   9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 8'sd0},
        '{9'd511, 9'd511, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0, 8'sd0},
        // Largest positive difference wraps to minus one and is marked changed.
        '{9'd100, 9'd100, 8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd100, 9'd100, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1, -8'sd1},
        '{9'd100, 9'd100, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 8'sd0},
        // Large negative difference blends the background, twice in a row.
        '{9'd200, 9'd200, 8'd128, 8'd128, 8'd128, 1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd200, 9'd200, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 8'sd0},
        '{9'd200, 9'd200, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 8'sd0},
        // Last column inside, and the column before the larger corner, which is outside.
        '{9'd509, 9'd300, 8'd50,  8'd60,  8'd70,  1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd509, 9'd300, 8'd50,  8'd60,  8'd70,  1'b0, 1'b0, 1'b0, 8'sd0},
        '{9'd510, 9'd300, 8'd50,  8'd60,  8'd70,  1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd510, 9'd300, 8'd1,   8'd2,   8'd3,   1'b0, 1'b1, 1'b0, 8'sd0},
        // First pixel inside the region.
        '{9'd1,   9'd1,   8'd255, 8'd0,   8'd255, 1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd1,   9'd1,   8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 1'b0, 8'sd0},
        // Last row inside, with each channel alone moving.
        '{9'd300, 9'd509, 8'd10,  8'd20,  8'd30,  1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd300, 9'd509, 8'd255, 8'd20,  8'd30,  1'b0, 1'b0, 1'b0, 8'sd0},
        '{9'd300, 9'd509, 8'd10,  8'd255, 8'd30,  1'b0, 1'b0, 1'b0, 8'sd0},
        '{9'd300, 9'd509, 8'd10,  8'd20,  8'd255, 1'b0, 1'b0, 1'b0, 8'sd0},
        // Row before the larger corner is outside; this site is never loaded.
        '{9'd300, 9'd510, 8'd9,   8'd9,   8'd9,   1'b0, 1'b1, 1'b0, 8'sd0},
        // Alternating bit patterns on coordinates and channels.
        '{9'd170, 9'd341, 8'd170, 8'd85,  8'd170, 1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd170, 9'd341, 8'd85,  8'd170, 8'd85,  1'b0, 1'b0, 1'b0, 8'sd0},
        '{9'd341, 9'd170, 8'd85,  8'd170, 8'd85,  1'b1, 1'b1, 1'b0, 8'sd0},
        '{9'd341, 9'd170, 8'd170, 8'd85,  8'd170, 1'b0, 1'b0, 1'b0, 8'sd0}
    };

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_addr    = REG_THRESHOLD;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;

    // Predictor copy of the settings and of the background store.
    logic signed [7:0] cur_threshold = THRESHOLD_RESET;
    logic [15:0]       cur_rate      = RATE_RESET;
    logic [8:0]        cur_x_low     = COORD_LOW_RESET;
    logic [8:0]        cur_x_high    = COORD_HIGH_RESET;
    logic [8:0]        cur_y_low     = COORD_LOW_RESET;
    logic [8:0]        cur_y_high    = COORD_HIGH_RESET;
    logic [23:0]       bg_store  [SITE_COUNT];
    bit                bg_loaded [SITE_COUNT];
    int                recent_sites[$];

    outcome_t pending_results[$];
    int       failures     = 0;
    int       results_seen = 0;
    int       burst_left   = 0;

    running_average_background_subtractor i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int site_of(input logic [8:0] x, input logic [8:0] y);
        return int'(y) * FRAME_W + int'(x);
    endfunction

    // Strictly between the smaller and larger corner, leaving out the line before the larger.
    function automatic bit in_span(input logic [8:0] v, input logic [8:0] a, input logic [8:0] b);
        int lo;
        int hi;
        lo = (a < b) ? int'(a) : int'(b);
        hi = (a < b) ? int'(b) : int'(a);
        return int'(v) > lo && int'(v) + 1 < hi;
    endfunction

    function automatic bit in_region(input logic [8:0] x, input logic [8:0] y);
        return in_span(x, cur_x_low, cur_x_high) && in_span(y, cur_y_low, cur_y_high);
    endfunction

    function automatic logic [7:0] blend_toward(input logic [7:0] pix, input logic [7:0] bg);
        int mix;
        mix = int'(cur_rate) * int'(pix) + (65536 - int'(cur_rate)) * int'(bg);
        return mix[23:16];
    endfunction

    // Works out the result of one pixel and updates the background copy.
    function automatic outcome_t predict_outcome(input pixel_t p);
        outcome_t    res;
        int          site;
        int          weighted;
        int          quotient;
        logic [23:0] bg;
        res  = '0;
        site = site_of(p.pixel_x, p.pixel_y);
        if (p.load_background) begin
            bg_store[site]  = {p.red, p.green, p.blue};
            bg_loaded[site] = 1'b1;
            recent_sites.push_back(site);
            if (recent_sites.size() > RECENT_LIMIT) void'(recent_sites.pop_front());
            return res;
        end
        if (!in_region(p.pixel_x, p.pixel_y)) return res;
        bg = bg_store[site];
        weighted = int'(WEIGHT_RED) * (int'(p.red) - int'(bg[23:16]))
                 + int'(WEIGHT_GREEN) * (int'(p.green) - int'(bg[15:8]))
                 + int'(WEIGHT_BLUE) * (int'(p.blue) - int'(bg[7:0]));
        // Division truncates toward zero; only the low byte survives.
        quotient = weighted / 65536;
        res.luma_difference = quotient[7:0];
        if (int'(res.luma_difference) < int'(cur_threshold)) begin
            bg_store[site] = {blend_toward(p.red, bg[23:16]), blend_toward(p.green, bg[15:8]),
                              blend_toward(p.blue, bg[7:0])};
        end else begin
            res.changed = 1'b1;
        end
        return res;
    endfunction

    // A coordinate inside the region on one axis when there is one, else anywhere.
    function automatic logic [8:0] coord_inside(input logic [8:0] a, input logic [8:0] b);
        int lo;
        int hi;
        lo = (a < b) ? int'(a) : int'(b);
        hi = (a < b) ? int'(b) : int'(a);
        if (hi - lo >= 3) return 9'($urandom_range(lo + 1, hi - 2));
        return 9'($urandom_range(0, 511));
    endfunction

    // A channel near its background value, clamped to the byte range.
    function automatic logic [7:0] nudge(input logic [7:0] ch, input int spread);
        int v;
        v = int'(ch) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Mostly loads followed by repeated pixels at loaded sites, with some noise.
    function automatic pixel_t next_pixel();
        pixel_t      p;
        int          choice;
        int          site;
        int          spread;
        logic [23:0] bg;
        p.red             = 8'($urandom);
        p.green           = 8'($urandom);
        p.blue            = 8'($urandom);
        p.pixel_x         = 9'($urandom);
        p.pixel_y         = 9'($urandom);
        p.load_background = 1'b0;
        choice = $urandom_range(0, 99);
        if (choice < 12) begin
            p.load_background = 1'b1;
        end else if (choice < 30) begin
            p.pixel_x         = coord_inside(cur_x_low, cur_x_high);
            p.pixel_y         = coord_inside(cur_y_low, cur_y_high);
            p.load_background = 1'b1;
        end else if (choice < 85 && recent_sites.size() > 0) begin
            // Recent sites give back-to-back updates of the same location.
            if (choice < 55 && recent_sites.size() > 4)
                site = recent_sites[recent_sites.size() - 1 - $urandom_range(0, 3)];
            else
                site = recent_sites[$urandom_range(0, recent_sites.size() - 1)];
            p.pixel_x = 9'(site % FRAME_W);
            p.pixel_y = 9'(site / FRAME_W);
            if ($urandom_range(0, 3) != 0) begin
                bg = bg_store[site];
                case ($urandom_range(0, 2))
                    0:       spread = 4;
                    1:       spread = 32;
                    default: spread = 255;
                endcase
                p.red   = nudge(bg[23:16], spread);
                p.green = nudge(bg[15:8], spread);
                p.blue  = nudge(bg[7:0], spread);
            end
        end
        // Never read a background that has not been loaded.
        site = site_of(p.pixel_x, p.pixel_y);
        if (!p.load_background && in_region(p.pixel_x, p.pixel_y) && !bg_loaded[site])
            p.load_background = 1'b1;
        return p;
    endfunction

    // Offers one pixel in bursts with random gaps and returns once the transaction is taken.
    task automatic send_pixel(input pixel_t p);
        int pick;
        int gap;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)      gap = 0;
            else if (pick < 9) gap = $urandom_range(1, 6);
            else               gap = $urandom_range(15, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, p.blue, p.green, p.red, p.pixel_y, p.pixel_x};
        s_tuser  <= p.load_background;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Stops offering and waits until every result is back and the pipeline is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all six registers, one per cycle, and mirrors them in the predictor.
    task automatic apply_settings(input logic [7:0] thr, input logic [15:0] rate,
                                  input logic [8:0] x_lo, input logic [8:0] x_hi,
                                  input logic [8:0] y_lo, input logic [8:0] y_hi);
        logic [2:0]  indexes [6];
        logic [15:0] values [6];
        indexes = '{REG_THRESHOLD, REG_RATE, REG_X_LOW, REG_X_HIGH, REG_Y_LOW, REG_Y_HIGH};
        values  = '{{{8{thr[7]}}, thr}, rate, {7'd0, x_lo}, {7'd0, x_hi},
                    {7'd0, y_lo}, {7'd0, y_hi}};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= indexes[i];
            cfg_wr_data <= values[i];
            @(posedge aclk);
        end
        cfg_wr_en     <= 1'b0;
        cur_threshold = thr;
        cur_rate      = rate;
        cur_x_low     = x_lo;
        cur_x_high    = x_hi;
        cur_y_low     = y_lo;
        cur_y_high    = y_hi;
    endtask

    // Compares one result transaction with the oldest expectation.
    task automatic check_result(input logic [15:0] word);
        outcome_t want;
        outcome_t got;
        got = {word[0], word[8:1]};
        if (pending_results.size() == 0) begin
            failures++;
            $error("result %h arrived with nothing expected", word);
        end else begin
            want = pending_results.pop_front();
            if (got.changed !== want.changed) begin
                failures++;
                $error("changed: expected %0d, got %0d", want.changed, got.changed);
            end
            if (got.luma_difference !== want.luma_difference) begin
                failures++;
                $error("luma_difference: expected %0d, got %0d",
                       want.luma_difference, got.luma_difference);
            end
        end
    endtask

    // Result side: a changing stall pattern, plus long hold-offs that fill the block up.
    initial begin : result_sink
        logic [15:0] ready_pattern;
        int          pattern_age;
        int          hold_left;
        int          next_hold_at;
        ready_pattern = '1;
        pattern_age   = 0;
        hold_left     = 0;
        next_hold_at  = 250;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_result(m_tdata);
                results_seen++;
            end
            if (hold_left == 0 && results_seen >= next_hold_at) begin
                hold_left    = 300;
                next_hold_at = next_hold_at + 600;
            end
            if (pattern_age == 0) begin
                pattern_age = 64;
                case ($urandom_range(0, 2))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom);
                    default: ready_pattern = 16'($urandom | $urandom);
                endcase
            end
            pattern_age--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ready_pattern[pattern_age % 16];
            end
        end
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence: reset, directed pixels, then random phases under several settings.
    initial begin : stimulus
        pixel_t     p;
        outcome_t   predicted;
        probe_row_t row;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PROBE_COUNT; i++) begin
            row = PROBE_ROWS[i];
            p   = '{row.pixel_x, row.pixel_y, row.red, row.green, row.blue,
                    row.load_background};
            send_pixel(p);
            predicted = predict_outcome(p);
            pending_results.push_back(row.typed ? outcome_t'({row.changed, row.luma_difference})
                                                : predicted);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            case (ph)
                0: apply_settings(-8'sd10, 16'd2185, 9'd0, 9'd511, 9'd0, 9'd511);
                1: apply_settings(-8'sd128, 16'd0, 9'd511, 9'd0, 9'd511, 9'd0);
                2: apply_settings(8'sd127, 16'hFFFF, 9'd20, 9'd60, 9'd60, 9'd20);
                3: apply_settings(8'sd0, 16'd32768, 9'd100, 9'd103, 9'd5, 9'd300);
                6: apply_settings(8'sd5, 16'd1, 9'd0, 9'd0, 9'd0, 9'd0);
                default: apply_settings(8'($urandom), 16'($urandom), 9'($urandom),
                                        9'($urandom), 9'($urandom), 9'($urandom));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                p = next_pixel();
                send_pixel(p);
                pending_results.push_back(predict_outcome(p));
            end
        end

        settle();
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
